// ===== rtl/lps_pkg.sv =====
// Shared constants and the controller/datapath command and status structs
// for the longest palindromic subsequence unit. No dependencies.
`timescale 1ns / 1ps

package lps_pkg;

  localparam int MAX_LEN  = 64;
  localparam int IDX_W    = $clog2(MAX_LEN);
  localparam int CNT_W    = $clog2(MAX_LEN + 1);
  localparam int DP_DEPTH = 1 << (2 * IDX_W);
  localparam int SYM_W    = 8;
  localparam int LEN_W    = 7;

  // Commands from the controller, one per datapath operation
  typedef struct packed {
    logic load;
    logic row_rd;
    logic row_wr;
    logic cell_rd;
    logic cell_wr;
    logic row_dec;
    logic len_rd;
    logic len_ld;
    logic walk_rd;
    logic walk_ex;
    logic emit_rd;
    logic emit_ld;
  } cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic row_has_cells;
    logic cell_last;
    logic i_zero;
    logic walk_cont;
    logic out_pop;
    logic out_last;
  } status_t;

endpackage

// ===== rtl/longest_palindromic_subsequence_unit.sv =====
// The closing byte of a string starts a table fill over its cells, a walk back through the table
// and emission of the palindrome bytes; the fill of the table memory dominates.
// Throughput: one string at a time; input is taken only while loading.
// Reset clears the load count, overflow flag, output valid and controller state; memories are
// not cleared.
// Top level: joins lps_ctrl and lps_datapath. Depends on lps_pkg.
`timescale 1ns / 1ps

module longest_palindromic_subsequence_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic        s_tlast,   // end_of_string
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_symbol, [14:8] pal_length, [15] zero
  output logic        m_tlast,   // out_last
  output logic        m_tuser    // truncated
);

  lps_pkg::cmd_t    cmd;
  lps_pkg::status_t status;

  lps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tlast(s_tlast),
    .s_tready(s_tready), .cmd(cmd), .status(status)
  );

  lps_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

endmodule

// ===== rtl/lps_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/lps_datapath.sv =====
// Datapath: string, table and palindrome memories, counters and output register.
// Depends on lps_pkg and lps_ram.
`timescale 1ns / 1ps

module lps_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  lps_pkg::cmd_t            cmd,
  output lps_pkg::status_t         status,
  input  logic [7:0]               s_tdata,
  input  logic                     s_tlast,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [15:0]              m_tdata,
  output logic                     m_tlast,
  output logic                     m_tuser
);

  localparam int IW = lps_pkg::IDX_W;
  localparam int CW = lps_pkg::CNT_W;
  localparam int LW = lps_pkg::LEN_W;
  localparam int SW = lps_pkg::SYM_W;

  logic [CW-1:0] cnt, cnt_next, n, j, wi, wj;
  logic          ovf;
  logic [IW-1:0] i;
  logic [SW-1:0] si;
  logic [LW-1:0] prev, diag, len, k0, k, cell_v;
  logic [SW-1:0] out_sym;

  logic          str_we, dp_we;
  logic [IW-1:0] str_waddr, str_ra, str_rb, pal_ra;
  logic [SW-1:0] str_da, str_db, pal_d, pal_unused;
  logic [2*IW-1:0] dp_waddr, dp_ra, dp_rb;
  logic [LW-1:0] dp_wdata, dp_da, dp_db;
  logic          sym_eq, pop;
  logic [LW-1:0] rk;

  // Memories
  lps_ram #(.WIDTH(SW), .DEPTH(lps_pkg::MAX_LEN)) u_str (
    .clk(clk), .we(str_we), .waddr(str_waddr), .wdata(s_tdata),
    .raddr_a(str_ra), .raddr_b(str_rb), .rdata_a(str_da), .rdata_b(str_db)
  );

  lps_ram #(.WIDTH(LW), .DEPTH(lps_pkg::DP_DEPTH)) u_dp (
    .clk(clk), .we(dp_we), .waddr(dp_waddr), .wdata(dp_wdata),
    .raddr_a(dp_ra), .raddr_b(dp_rb), .rdata_a(dp_da), .rdata_b(dp_db)
  );

  lps_ram #(.WIDTH(SW), .DEPTH(lps_pkg::MAX_LEN)) u_pal (
    .clk(clk), .we(cmd.walk_ex && sym_eq), .waddr(k0[IW-1:0]), .wdata(str_da),
    .raddr_a(pal_ra), .raddr_b(pal_ra), .rdata_a(pal_d), .rdata_b(pal_unused)
  );

  // Address selection and cell evaluation
  always_comb begin
    str_we    = cmd.load && (cnt < CW'(lps_pkg::MAX_LEN));
    str_waddr = cnt[IW-1:0];
    cnt_next  = str_we ? cnt + CW'(1) : cnt;
    str_rb    = wj[IW-1:0];
    if (cmd.row_rd) begin
      str_ra = i;
    end else if (cmd.cell_rd) begin
      str_ra = j[IW-1:0];
    end else begin
      str_ra = wi[IW-1:0];
    end
    if (cmd.cell_rd) begin
      dp_ra = {i + IW'(1), j[IW-1:0]};
    end else if (cmd.len_rd) begin
      dp_ra = {IW'(0), IW'(n - CW'(1))};
    end else begin
      dp_ra = {wi[IW-1:0], wj[IW-1:0]};
    end
    dp_rb  = {IW'(wi + CW'(1)), wj[IW-1:0]};
    sym_eq = (str_da == str_db);
    if (si == str_da) begin
      cell_v = diag + LW'(2);
    end else begin
      cell_v = (dp_da > prev) ? dp_da : prev;
    end
    dp_we    = cmd.row_wr || cmd.cell_wr;
    dp_waddr = cmd.row_wr ? {i, i} : {i, j[IW-1:0]};
    dp_wdata = cmd.row_wr ? LW'(1) : cell_v;
    rk       = len - LW'(1) - k;
    pal_ra   = (k <= rk) ? k[IW-1:0] : rk[IW-1:0];
    pop      = m_tvalid && m_tready;
  end

  // Status to the controller
  always_comb begin
    status.row_has_cells = (CW'(i) + CW'(1)) < n;
    status.cell_last     = (j + CW'(1)) == n;
    status.i_zero        = (i == IW'(0));
    if (sym_eq) begin
      status.walk_cont = (wi + CW'(2)) <= wj;
    end else if (dp_da == dp_db) begin
      status.walk_cont = (wi + CW'(1)) <= wj;
    end else begin
      status.walk_cont = wj > wi;
    end
    status.out_pop  = pop;
    status.out_last = m_tlast;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt <= cnt_next;
        if (!str_we) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.emit_ld) begin
        m_tvalid <= 1'b1;
      end else if (pop) begin
        m_tvalid <= 1'b0;
        if (m_tlast) begin
          cnt <= '0;
          ovf <= 1'b0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load && s_tlast) begin
      n <= cnt_next;
      i <= IW'(cnt_next - CW'(1));
    end
    if (cmd.row_dec) begin
      i <= i - IW'(1);
    end
    if (cmd.row_wr) begin
      si   <= str_da;
      prev <= LW'(1);
      diag <= '0;
      j    <= CW'(i) + CW'(1);
    end
    if (cmd.cell_wr) begin
      prev <= cell_v;
      diag <= dp_da;
      j    <= j + CW'(1);
    end
    if (cmd.len_ld) begin
      len <= dp_da;
      wi  <= '0;
      wj  <= n - CW'(1);
      k0  <= '0;
      k   <= '0;
    end
    if (cmd.walk_ex) begin
      if (sym_eq) begin
        k0 <= k0 + LW'(1);
        wi <= wi + CW'(1);
        wj <= wj - CW'(1);
      end else if (dp_da == dp_db) begin
        wi <= wi + CW'(1);
      end else begin
        wj <= wj - CW'(1);
      end
    end
    if (cmd.emit_ld) begin
      out_sym <= pal_d;
      m_tlast <= (k + LW'(1)) == len;
      m_tuser <= ovf;
    end
    if (pop) begin
      k <= k + LW'(1);
    end
  end

  assign m_tdata = {1'b0, len, out_sym};

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> len != '0) else $error("result offered with zero length");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
  a_k0: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_ex |-> k0 < len) else $error("walk overran palindrome");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(lps_pkg::MAX_LEN)) else $error("load count beyond capacity");

endmodule

// ===== rtl/lps_ctrl.sv =====
// Controller: sequences load, table fill, walk back and emission.
// Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tlast,
  output logic             s_tready,
  output lps_pkg::cmd_t    cmd,
  input  lps_pkg::status_t status
);

  typedef enum logic [3:0] {
    LOAD, ROW_RD, ROW_WR, CELL_RD, CELL_WR, ROW_END, LEN_RD, LEN_LD,
    WALK_RD, WALK_EX, EMIT_RD, EMIT_LD, EMIT_WAIT
  } state_t;

  state_t state;

  assign s_tready = (state == LOAD);

  // Decode commands from the state
  always_comb begin
    cmd         = '0;
    cmd.load    = (state == LOAD) && s_tvalid;
    cmd.row_rd  = (state == ROW_RD);
    cmd.row_wr  = (state == ROW_WR);
    cmd.cell_rd = (state == CELL_RD);
    cmd.cell_wr = (state == CELL_WR);
    cmd.row_dec = (state == ROW_END) && !status.i_zero;
    cmd.len_rd  = (state == LEN_RD);
    cmd.len_ld  = (state == LEN_LD);
    cmd.walk_rd = (state == WALK_RD);
    cmd.walk_ex = (state == WALK_EX);
    cmd.emit_rd = (state == EMIT_RD);
    cmd.emit_ld = (state == EMIT_LD);
  end

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
    end else begin
      unique case (state)
        LOAD:      if (s_tvalid && s_tlast) state <= ROW_RD;
        ROW_RD:    state <= ROW_WR;
        ROW_WR:    state <= status.row_has_cells ? CELL_RD : ROW_END;
        CELL_RD:   state <= CELL_WR;
        CELL_WR:   state <= status.cell_last ? ROW_END : CELL_RD;
        ROW_END:   state <= status.i_zero ? LEN_RD : ROW_RD;
        LEN_RD:    state <= LEN_LD;
        LEN_LD:    state <= WALK_RD;
        WALK_RD:   state <= WALK_EX;
        WALK_EX:   state <= status.walk_cont ? WALK_RD : EMIT_RD;
        EMIT_RD:   state <= EMIT_LD;
        EMIT_LD:   state <= EMIT_WAIT;
        EMIT_WAIT: if (status.out_pop) state <= status.out_last ? LOAD : EMIT_RD;
        default:   state <= LOAD;
      endcase
    end
  end

endmodule
